// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is active.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a condition to a property, disabled while reset is active.
`define ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== hdl/rcmt_pkg.sv =====
// Shared types and constants for the RGBA color matrix transform.
// No dependencies.
package rcmt_pkg;

  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned ROW_W   = NUM_CH * COEFF_W;
  // 16b signed coefficient times 9b signed (zero-extended) channel
  localparam int unsigned PROD_W  = COEFF_W + CHAN_W + 1;
  localparam int unsigned PAIR_W  = PROD_W + 1;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned IDX_W   = 2;

  localparam logic [CHAN_W-1:0] CH_MAX = 8'hFF;
  localparam logic [CHAN_W-1:0] CH_MIN = 8'h00;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [NUM_CH-1:0][CHAN_W-1:0] pixel_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_RED   = 2'd0,
    REG_ROW_GREEN = 2'd1,
    REG_ROW_BLUE  = 2'd2,
    REG_ROW_ALPHA = 2'd3
  } cfg_idx_e;

endpackage

// ===== hdl/rgba_color_matrix_transform.sv =====
// Top level of the RGBA 4x4 color matrix transform: row registers, input stage,
// four rcmt_dot lanes, four rcmt_sat stages. Uses rcmt_pkg and assert_macros.svh.
//
//  channel   signals                                        dir
//  pixel in  start_i busy_o in_*_i last_pixel_i             in
//  result    valid_o out_*_o out_last_o                     out
//  config    cfg_we_i cfg_idx_i cfg_data_i                  in
//
// One pixel is taken per clock; busy_o never rises.
// A pixel passes through the input register, products, pair sums, total and saturate registers.
// Reset clears the valid pipeline and loads the identity matrix.
// The receiver cannot stall, so the pipeline advances every cycle.
`include "assert_macros.svh"

module rgba_color_matrix_transform #(
  parameter int unsigned COEFF_FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rcmt_pkg::CHAN_W-1:0]       in_red_i,
  input  logic [rcmt_pkg::CHAN_W-1:0]       in_green_i,
  input  logic [rcmt_pkg::CHAN_W-1:0]       in_blue_i,
  input  logic [rcmt_pkg::CHAN_W-1:0]       in_alpha_i,
  input  logic                              last_pixel_i,
  output logic                              valid_o,
  output logic [rcmt_pkg::CHAN_W-1:0]       out_red_o,
  output logic [rcmt_pkg::CHAN_W-1:0]       out_green_o,
  output logic [rcmt_pkg::CHAN_W-1:0]       out_blue_o,
  output logic [rcmt_pkg::CHAN_W-1:0]       out_alpha_o,
  output logic                              out_last_o,
  input  logic                              cfg_we_i,
  input  logic [rcmt_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [rcmt_pkg::ROW_W-1:0]        cfg_data_i
);
  import rcmt_pkg::*;

  localparam int unsigned LAT = 5;
  localparam logic [COEFF_W-1:0] ONE = COEFF_W'(1) << COEFF_FRAC_BITS;
  localparam row_t RST_RED   = ROW_W'(ONE);
  localparam row_t RST_GREEN = ROW_W'(ONE) << COEFF_W;
  localparam row_t RST_BLUE  = ROW_W'(ONE) << (2 * COEFF_W);
  localparam row_t RST_ALPHA = ROW_W'(ONE) << (3 * COEFF_W);

  row_t              row_q [NUM_CH];
  pixel_t            px_q;
  logic [LAT-1:0]    valid_q;
  logic [LAT-1:0]    last_q;
  logic              accept;
  acc_t              sum   [NUM_CH];
  logic [CHAN_W-1:0] chan  [NUM_CH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= RST_RED;
      row_q[1] <= RST_GREEN;
      row_q[2] <= RST_BLUE;
      row_q[3] <= RST_ALPHA;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_RED:   row_q[0] <= cfg_data_i;
        REG_ROW_GREEN: row_q[1] <= cfg_data_i;
        REG_ROW_BLUE:  row_q[2] <= cfg_data_i;
        REG_ROW_ALPHA: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= {last_q[LAT-2:0], last_pixel_i};
    if (accept) begin
      px_q <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    rcmt_dot u_dot (
      .clk_i (clk_i),
      .row_i (row_q[c]),
      .px_i  (px_q),
      .sum_o (sum[c])
    );
    rcmt_sat #(
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_sat (
      .clk_i  (clk_i),
      .acc_i  (sum[c]),
      .chan_o (chan[c])
    );
  end

  assign valid_o     = valid_q[LAT-1];
  assign out_last_o  = last_q[LAT-1];
  assign out_red_o   = chan[0];
  assign out_green_o = chan[1];
  assign out_blue_o  = chan[2];
  assign out_alpha_o = chan[3];

  `ASSERT_IMPLY(a_accept_gives_result, accept, ##LAT valid_o, "accepted pixel gave no result")
  `ASSERT_IMPLY(a_result_has_source, valid_o, $past(accept, LAT), "result without a transaction")
  `ASSERT_IMPLY(a_last_follows, accept, ##LAT (out_last_o == $past(last_pixel_i, LAT)),
                "last flag lost its pixel")
  `ASSERT_CLK(a_never_busy, !busy_o, "busy raised")

endmodule

// ===== hdl/rcmt_dot.sv =====
// One output channel: four-term dot product of a coefficient row and a pixel.
// Three register stages: products, pair sums, total. Uses rcmt_pkg.
module rcmt_dot (
  input  logic            clk_i,
  input  rcmt_pkg::row_t   row_i,
  input  rcmt_pkg::pixel_t px_i,
  output rcmt_pkg::acc_t   sum_o
);
  import rcmt_pkg::*;

  logic signed [PROD_W-1:0] prod_d [NUM_CH];
  logic signed [PROD_W-1:0] prod_q [NUM_CH];
  logic signed [PAIR_W-1:0] pair_d [2];
  logic signed [PAIR_W-1:0] pair_q [2];
  acc_t                     sum_d;
  acc_t                     sum_q;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod_d[k] = PROD_W'($signed(row_i[COEFF_W*k +: COEFF_W]))
                * PROD_W'($signed({1'b0, px_i[k]}));
    end
    pair_d[0] = PAIR_W'(prod_q[0]) + PAIR_W'(prod_q[1]);
    pair_d[1] = PAIR_W'(prod_q[2]) + PAIR_W'(prod_q[3]);
    sum_d     = ACC_W'(pair_q[0]) + ACC_W'(pair_q[1]);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pair_q <= pair_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

// ===== hdl/rcmt_sat.sv =====
// Saturate a fixed-point dot product to an 8-bit channel, registered output.
// Uses rcmt_pkg.
module rcmt_sat #(
  parameter int unsigned COEFF_FRAC_BITS = 12
) (
  input  logic                         clk_i,
  input  rcmt_pkg::acc_t               acc_i,
  output logic [rcmt_pkg::CHAN_W-1:0]  chan_o
);
  import rcmt_pkg::*;

  logic [CHAN_W-1:0] chan_d;
  logic [CHAN_W-1:0] chan_q;
  logic              over;

  // any integer bit at or above 256 set means saturation high
  assign over = |acc_i[ACC_W-2:COEFF_FRAC_BITS+CHAN_W];

  always_comb begin
    if (acc_i[ACC_W-1]) begin
      chan_d = CH_MIN;
    end else if (over) begin
      chan_d = CH_MAX;
    end else begin
      chan_d = acc_i[COEFF_FRAC_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

// ===== dv/tb_rgba_color_matrix_transform.sv =====
// Self-checking testbench for rgba_color_matrix_transform: queue-fed pixel driver,
// result monitor with a bit-accurate matrix predictor, and row register writes between phases.
// Depends on rcmt_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_rgba_color_matrix_transform;
  import rcmt_pkg::*;

  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned GAP_PCT     = 16;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } rgba_px_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start_i      = 1'b0;
  logic              busy_o;
  logic [CHAN_W-1:0] in_red_i     = '0;
  logic [CHAN_W-1:0] in_green_i   = '0;
  logic [CHAN_W-1:0] in_blue_i    = '0;
  logic [CHAN_W-1:0] in_alpha_i   = '0;
  logic              last_pixel_i = 1'b0;
  logic              valid_o;
  logic [CHAN_W-1:0] out_red_o;
  logic [CHAN_W-1:0] out_green_o;
  logic [CHAN_W-1:0] out_blue_o;
  logic [CHAN_W-1:0] out_alpha_o;
  logic              out_last_o;
  logic              cfg_we_i     = 1'b0;
  cfg_idx_e          cfg_idx_i    = REG_ROW_RED;
  row_t              cfg_data_i   = '0;

  rgba_color_matrix_transform #(
    .COEFF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .in_alpha_i  (in_alpha_i),
    .last_pixel_i(last_pixel_i),
    .valid_o     (valid_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o),
    .out_last_o  (out_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Testbench copy of the row registers, identity after reset
  row_t coeff_rows [4] = '{row_t'(64'h0000_0000_0000_1000), row_t'(64'h0000_0000_1000_0000),
                           row_t'(64'h0000_1000_0000_0000), row_t'(64'h1000_0000_0000_0000)};

  rgba_px_t    pixel_q [$];
  rgba_px_t    transformed_q [$];
  bit          gaps_on     = 1'b1;
  bit          feed_hold   = 1'b0;
  bit          taken       = 1'b0;
  int unsigned err_count   = 0;
  int unsigned results_seen = 0;
  int unsigned textures_done = 0;
  int unsigned cfg_writes  = 0;
  int unsigned matrices    = 1;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------- predictor

  function automatic logic [CHAN_W-1:0] mix_channel(row_t row, rgba_px_t p);
    logic [CHAN_W-1:0]         ch [4];
    logic signed [COEFF_W-1:0] c;
    longint                    acc;
    ch  = '{p.red, p.green, p.blue, p.alpha};
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      c   = row[COEFF_W*k +: COEFF_W];
      acc += longint'(c) * longint'(ch[k]);
    end
    if (acc < 0) return CH_MIN;
    if (acc >= (longint'(256) << FRAC_BITS)) return CH_MAX;
    return CHAN_W'(acc >>> FRAC_BITS);
  endfunction

  function automatic rgba_px_t transform_pixel(rgba_px_t p);
    rgba_px_t o;
    o.red   = mix_channel(coeff_rows[REG_ROW_RED], p);
    o.green = mix_channel(coeff_rows[REG_ROW_GREEN], p);
    o.blue  = mix_channel(coeff_rows[REG_ROW_BLUE], p);
    o.alpha = mix_channel(coeff_rows[REG_ROW_ALPHA], p);
    o.last  = p.last;
    return o;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_error(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_chan(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got %0h, expected %0h", results_seen, name, got, want));
  endtask

  // Monitor: checks results first, then records the transaction taken at this edge
  always @(posedge clk_i) begin : monitor
    rgba_px_t want;
    rgba_px_t seen_px;
    if (rst_ni) begin
      if (valid_o) begin
        if (transformed_q.size() == 0) begin
          flag_error("result strobe with no transaction outstanding");
        end else begin
          want = transformed_q.pop_front();
          check_chan("red", want.red, out_red_o);
          check_chan("green", want.green, out_green_o);
          check_chan("blue", want.blue, out_blue_o);
          check_chan("alpha", want.alpha, out_alpha_o);
          if (out_last_o !== want.last)
            flag_error($sformatf("result %0d last: got %b, expected %b",
                                 results_seen, out_last_o, want.last));
          results_seen++;
        end
      end
      if (start_i && !busy_o) begin
        seen_px = '{in_red_i, in_green_i, in_blue_i, in_alpha_i, last_pixel_i};
        transformed_q.push_back(transform_pixel(seen_px));
        if (last_pixel_i) textures_done++;
        taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin : driver
    rgba_px_t px;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !taken) begin
      // hold the current pixel until it is taken
    end else if (pixel_q.size() != 0 && !feed_hold &&
                 !(gaps_on && $urandom_range(0, 99) < GAP_PCT)) begin
      px = pixel_q.pop_front();
      in_red_i     <= px.red;
      in_green_i   <= px.green;
      in_blue_i    <= px.blue;
      in_alpha_i   <= px.alpha;
      last_pixel_i <= px.last;
      start_i      <= 1'b1;
    end else begin
      start_i <= 1'b0;
    end
    taken = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, transformed_q.size());
      $display("tb_rgba_color_matrix_transform: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic row_t pack_row(logic [COEFF_W-1:0] c_r, logic [COEFF_W-1:0] c_g,
                                    logic [COEFF_W-1:0] c_b, logic [COEFF_W-1:0] c_a);
    return {c_a, c_b, c_g, c_r};
  endfunction

  function automatic logic [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0:       return COEFF_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return COEFF_W'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic row_t rand_row();
    return pack_row(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return CH_MIN;
      1:       return CH_MAX;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_px(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                         logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a, logic last);
    pixel_q.push_back('{r, g, b, a, last});
  endtask

  // Textures of random length ending in a last mark; about one last flag in twenty is flipped as noise
  task automatic queue_textures(int unsigned count);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    while (queued < count) begin
      len = $urandom_range(1, 24);
      if (len > count - queued) len = count - queued;
      for (int unsigned i = 0; i < len; i++)
        push_px(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                (i == len - 1) ^ ($urandom_range(0, 19) == 0));
      queued += len;
    end
  endtask

  task automatic wait_drain();
    wait (pixel_q.size() == 0 && !start_i && transformed_q.size() == 0);
  endtask

  task automatic load_row(cfg_idx_e idx, row_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    coeff_rows[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic load_matrix(row_t r_row, row_t g_row, row_t b_row, row_t a_row);
    load_row(REG_ROW_RED, r_row);
    load_row(REG_ROW_GREEN, g_row);
    load_row(REG_ROW_BLUE, b_row);
    load_row(REG_ROW_ALPHA, a_row);
    matrices++;
  endtask

  task automatic run_phase(int unsigned count);
    queue_textures(count);
    wait_drain();
  endtask

  // ---------------------------------------------------------------- test sequence

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // identity matrix from reset
    push_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_px(8'hFF, 8'h00, 8'h80, 8'h01, 1'b0);
    push_px(8'h01, 8'h02, 8'h03, 8'h04, 1'b1);
    wait_drain();

    // largest positive coefficients everywhere
    load_matrix(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    push_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_drain();

    // most negative coefficients: every channel clamps low
    load_matrix(pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    push_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    wait_drain();

    // red: exactly 256.0 vs just below; green: tiny negative sum;
    // blue: half weight truncates; alpha: near-cancelling extremes
    load_matrix(pack_row(16'h1000, 16'h1000, 16'h0000, 16'h0000),
                pack_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000),
                pack_row(16'h0800, 16'h0000, 16'h0000, 16'h0000),
                pack_row(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF));
    push_px(8'h80, 8'h80, 8'h00, 8'h00, 1'b0);
    push_px(8'h80, 8'h7F, 8'h00, 8'h00, 1'b0);
    push_px(8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
    push_px(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
    push_px(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
    wait_drain();

    // random matrices with random textures
    load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
    run_phase(100);

    gaps_on = 1'b0;
    load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
    run_phase(120);
    gaps_on = 1'b1;

    load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    run_phase(80);

    // stop feeding halfway until the pipeline has emptied
    load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
    queue_textures(100);
    wait (pixel_q.size() <= 50);
    feed_hold = 1'b1;
    wait (!start_i && transformed_q.size() == 0);
    feed_hold = 1'b0;
    wait_drain();

    load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
    run_phase(100);

    repeat (8) @(posedge clk_i);
    $display("Covered %0d pixels (%0d texture ends) over %0d matrices, %0d row writes",
             results_seen, textures_done, matrices, cfg_writes);
    if (err_count == 0) begin
      $display("tb_rgba_color_matrix_transform: PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_rgba_color_matrix_transform: FAIL");
    end
    $finish;
  end

endmodule
